FILE: hdl/servo_pulse_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Servo pulse sequencer assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_SEQUENCER_MACROS_SVH
`define SERVO_PULSE_SEQUENCER_MACROS_SVH

`ifndef SYNTH
// Check on every clock edge outside reset.
`define SPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define SPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/sps_pkg.sv
// ----------------------------------------------------------------------------
// Servo pulse sequencer package
// Item types, table write request and fixed constants.
// ----------------------------------------------------------------------------
package sps_pkg;

  typedef enum logic {
    OP_ELAPSED = 1'b0,
    OP_WRITE   = 1'b1
  } sps_op_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_TICKS = 1'b1;

  localparam logic [15:0] PULSE_BASE     = 16'd1024;
  localparam logic [15:0] MIN_GAP        = 16'd1024;
  localparam logic [15:0] REFRESH_RESET  = 16'd40000;
  localparam int unsigned POSITION_SHIFT = 4;

  typedef struct packed {
    sps_op_e     operation;
    logic [2:0]  channel;
    logic [7:0]  position;
  } sps_in_t;

  typedef struct packed {
    logic [2:0]  active_channel;
    logic        pulse_on;
    logic [15:0] interval_ticks;
  } sps_out_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  addr;
    logic [7:0]  data;
  } sps_tbl_wr_t;

endpackage

FILE: hdl/sps_pos_table.sv
// ----------------------------------------------------------------------------
// Servo position table
// One position per channel, reset to the default position.
// ----------------------------------------------------------------------------
module sps_pos_table
  import sps_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS     = 8,
  parameter int unsigned DEFAULT_POSITION = 128,
  localparam int unsigned SLOT_W          = $clog2(MAX_CHANNELS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sps_tbl_wr_t       wr_i,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output logic [7:0]        rd_pos_o
);

  logic [7:0] pos_q [MAX_CHANNELS];

  // Writes to a channel beyond the table match no entry and are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pos_q[i] <= 8'(DEFAULT_POSITION);
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        if (32'(wr_i.addr) == i) begin
          pos_q[i] <= wr_i.data;
        end
      end
    end
  end

  always_comb begin
    rd_pos_o = pos_q[0];
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (32'(rd_idx_i) == i) begin
        rd_pos_o = pos_q[i];
      end
    end
  end

endmodule

FILE: hdl/sps_frame_ctrl.sv
`include "servo_pulse_sequencer_macros.svh"
// ----------------------------------------------------------------------------
// Servo frame control
// Slot counter, running pulse sum, table write request and result computation for one item.
// ----------------------------------------------------------------------------
module sps_frame_ctrl
  import sps_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8,
  localparam int unsigned SLOT_W      = $clog2(MAX_CHANNELS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sps_in_t           item_i,
  input  logic [3:0]        cnt_i,
  input  logic [15:0]       refresh_i,
  output logic [SLOT_W-1:0] rd_idx_o,
  input  logic [7:0]        rd_pos_i,
  output sps_tbl_wr_t       tbl_wr_o,
  output logic              res_valid_o,
  output sps_out_t          res_o
);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [15:0]       elapsed_q, elapsed_d;
  logic              pulse_slot;
  logic [15:0]       width;
  logic [16:0]       sum;
  logic [16:0]       diff;
  logic [15:0]       gap;
  logic              elapsed_op;

  assign elapsed_op = (item_i.operation == OP_ELAPSED);
  assign rd_idx_o   = slot_q;

  assign tbl_wr_o.en   = step_i && (item_i.operation == OP_WRITE);
  assign tbl_wr_o.addr = item_i.channel;
  assign tbl_wr_o.data = item_i.position;

  always_comb begin
    pulse_slot = (32'(slot_q) < 32'(cnt_i)) && (32'(slot_q) < MAX_CHANNELS);
    width      = PULSE_BASE + (16'(rd_pos_i) << POSITION_SHIFT);
    sum        = {1'b0, elapsed_q} + {1'b0, width};
    diff       = {1'b0, refresh_i} - {1'b0, elapsed_q};
    gap        = (diff[16] || (diff[15:0] < MIN_GAP)) ? MIN_GAP : diff[15:0];

    slot_d    = slot_q;
    elapsed_d = elapsed_q;
    res_valid_o = step_i && elapsed_op;
    if (pulse_slot) begin
      res_o.active_channel = 3'(slot_q);
      res_o.pulse_on       = 1'b1;
      res_o.interval_ticks = width;
    end else begin
      res_o.active_channel = 3'd0;
      res_o.pulse_on       = 1'b0;
      res_o.interval_ticks = gap;
    end

    if (step_i && elapsed_op) begin
      if (pulse_slot) begin
        slot_d    = slot_q + SLOT_W'(1);
        elapsed_d = sum[16] ? 16'hFFFF : sum[15:0];
      end else begin
        slot_d    = '0;
        elapsed_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      elapsed_q <= '0;
    end else begin
      slot_q    <= slot_d;
      elapsed_q <= elapsed_d;
    end
  end

  `SPS_ASSERT_ALWAYS(a_slot_range, clk_i, !rst_ni || 32'(slot_q) <= MAX_CHANNELS, "slot past channel limit")
  `SPS_ASSERT(a_gap_clears, clk_i, rst_ni, step_i && elapsed_op && !pulse_slot |=> slot_q == '0 && elapsed_q == '0, "gap did not end frame")
  `SPS_ASSERT(a_sum_grows, clk_i, rst_ni, step_i && elapsed_op && pulse_slot |=> elapsed_q >= $past(elapsed_q), "frame sum shrank on a pulse")

endmodule

FILE: hdl/servo_pulse_sequencer.sv
`include "servo_pulse_sequencer_macros.svh"
// ----------------------------------------------------------------------------
// Servo pulse sequencer
// Time-multiplexed servo frame: one pulse per channel in use, then a gap.
// ----------------------------------------------------------------------------
// A result passes through the input register and then the result register to out_item_o.
// Throughput: one item per cycle unless stalled; the slot and frame sum update in a single
//   pass of the frame control logic between the input and result registers.
//   An elapsed item waits in the input register while a stalled result holds.
// Reset: asynchronous, active low; every position returns to the default,
//   slot and frame sum clear, channel_count = 0, refresh_ticks = 40000.
module servo_pulse_sequencer
  import sps_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS     = 8,
  parameter int unsigned DEFAULT_POSITION = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sps_in_t               in_item_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sps_out_t              out_item_o
);

  localparam int unsigned SLOT_W = $clog2(MAX_CHANNELS + 1);

  // Configuration registers.
  logic [3:0]  cnt_q;
  logic [15:0] refresh_q;

  // Input register stage.
  logic    s1_valid_q, s1_valid_d;
  sps_in_t s1_item_q, s1_item_d;

  // Result register stage.
  logic     out_valid_q, out_valid_d;
  sps_out_t out_q, out_d;

  logic              go;
  logic              res_valid;
  sps_out_t          res;
  sps_tbl_wr_t       tbl_wr;
  logic [SLOT_W-1:0] rd_idx;
  logic [7:0]        rd_pos;

  // Write the configuration registers; unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      refresh_q <= REFRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHANNEL_COUNT: cnt_q     <= cfg_wdata_i[3:0];
        REG_REFRESH_TICKS: refresh_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // A position write never needs the result register, so it always moves on.
  // An elapsed item moves on once the result register is free or draining.
  assign go = s1_valid_q &&
              ((s1_item_q.operation == OP_WRITE) || !out_valid_q || !out_stall_i);

  assign in_stall_o = s1_valid_q && !go;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_item_d  = s1_item_q;
    // Refill the input register whenever it is empty or being drained.
    if (!s1_valid_q || go) begin
      s1_valid_d = in_valid_i;
      if (in_valid_i) begin
        s1_item_d = in_item_i;
      end
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    out_q     <= out_d;
  end

  sps_pos_table #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .DEFAULT_POSITION (DEFAULT_POSITION)
  ) u_pos_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_idx_i (rd_idx),
    .rd_pos_o (rd_pos)
  );

  sps_frame_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (go),
    .item_i      (s1_item_q),
    .cnt_i       (cnt_q),
    .refresh_i   (refresh_q),
    .rd_idx_o    (rd_idx),
    .rd_pos_i    (rd_pos),
    .tbl_wr_o    (tbl_wr),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SPS_ASSERT(a_gap_floor, clk_i, rst_ni, out_valid_o && !out_item_o.pulse_on |-> out_item_o.interval_ticks >= MIN_GAP, "gap below minimum")
  `SPS_ASSERT(a_pulse_shape, clk_i, rst_ni, out_valid_o && out_item_o.pulse_on |-> out_item_o.interval_ticks >= PULSE_BASE && out_item_o.interval_ticks[3:0] == 4'h0, "malformed pulse width")
  `SPS_ASSERT(a_gap_channel, clk_i, rst_ni, out_valid_o && !out_item_o.pulse_on |-> out_item_o.active_channel == 3'd0, "gap with nonzero channel")

endmodule
